/* rtl/pse_pkg.sv */
// Types, codes and a helper function shared by the postfix stack evaluator.
package pse_pkg;

  typedef struct packed {
    logic               is_operand;
    logic signed [15:0] operand_value;
    logic [1:0]         opcode;
    logic               end_of_expr;
  } token_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } result_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam int DIV_STEPS = 48;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_FIRST,
    S_RD_SECOND,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIV_FIX,
    S_WRITE,
    S_FINISH
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sh0000_7FFF_FFFF) begin
      r = Q_MAX;
    end else if (x < -48'sh0000_8000_0000) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/postfix_stack_evaluator.sv */
// Postfix expression evaluator in Q16.16 with a memory operand stack.
// Tokens are taken only in idle; an operand, or an operator on a short stack, ends at decode.
// Others read two entries and write one back; divide uses the 48-step divider unless by zero.
// A result becomes valid as the next token can be taken and waits in an output
// register; a second result waits in the last state until that register is free.
// Reset empties the stack and clears the error status; stack contents need no clearing.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_stall,
  input  pse_pkg::token_t  tok,
  output logic             res_valid,
  input  logic             res_stall,
  output pse_pkg::result_t res
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(pse_pkg::DIV_STEPS);

  pse_pkg::state_t state, state_next;

  pse_pkg::token_t    tok_q;
  logic [SPW-1:0]     sp;
  logic [1:0]         err;
  logic signed [31:0] bottom;
  logic signed [31:0] first;
  logic signed [31:0] wres;
  logic signed [63:0] prod;

  logic [31:0]        div_rem;
  logic [47:0]        div_quo;
  logic [31:0]        div_dsr;
  logic [CW-1:0]      div_cnt;
  logic               div_neg;

  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic               full;
  logic               short;
  logic               res_free;
  logic [32:0]        trial;
  logic               ge;
  logic signed [32:0] addsub;
  logic [31:0]        second_mag;
  logic [31:0]        first_mag;

  assign full     = (sp >= SPW'(STACK_DEPTH));
  assign short    = (sp < SPW'(2));
  assign res_free = !res_valid || !res_stall;

  assign trial = {div_rem, div_quo[47]};
  assign ge    = (trial >= {1'b0, div_dsr});

  assign addsub = (tok_q.opcode == pse_pkg::OP_SUB) ? (33'(rdata) - 33'(first))
                                                    : (33'(rdata) + 33'(first));
  assign second_mag = rdata[31] ? (~rdata + 32'd1) : rdata;
  assign first_mag  = first[31] ? (~first + 32'd1) : first;

  always_comb begin
    state_next = state;
    case (state)
      pse_pkg::S_IDLE: begin
        if (tok_valid) begin
          state_next = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        if (tok_q.is_operand || short) begin
          state_next = pse_pkg::S_FINISH;
        end else begin
          state_next = pse_pkg::S_RD_FIRST;
        end
      end
      pse_pkg::S_RD_FIRST:  state_next = pse_pkg::S_RD_SECOND;
      pse_pkg::S_RD_SECOND: state_next = pse_pkg::S_EXEC;
      pse_pkg::S_EXEC: begin
        case (tok_q.opcode)
          pse_pkg::OP_MUL: state_next = pse_pkg::S_MUL;
          pse_pkg::OP_DIV: state_next = (first == '0) ? pse_pkg::S_WRITE : pse_pkg::S_DIV;
          default:         state_next = pse_pkg::S_WRITE;
        endcase
      end
      pse_pkg::S_MUL: state_next = pse_pkg::S_WRITE;
      pse_pkg::S_DIV: begin
        if (div_cnt == CW'(pse_pkg::DIV_STEPS - 1)) begin
          state_next = pse_pkg::S_DIV_FIX;
        end
      end
      pse_pkg::S_DIV_FIX: state_next = pse_pkg::S_WRITE;
      pse_pkg::S_WRITE:   state_next = pse_pkg::S_FINISH;
      pse_pkg::S_FINISH: begin
        if (!tok_q.end_of_expr || res_free) begin
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: state_next = pse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tok_stall = (state != pse_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = sp[AW-1:0];
    mem_wdata = {tok_q.operand_value, 16'd0};
    mem_raddr = AW'(sp - SPW'(1));
    case (state)
      pse_pkg::S_DECODE: begin
        mem_we = tok_q.is_operand && !full;
      end
      pse_pkg::S_RD_SECOND: begin
        mem_raddr = AW'(sp - SPW'(2));
      end
      pse_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(sp - SPW'(2));
        mem_wdata = wres;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pse_pkg::S_IDLE;
      sp        <= '0;
      err       <= pse_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pse_pkg::S_FINISH && tok_q.end_of_expr && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        pse_pkg::S_DECODE: begin
          if (tok_q.is_operand) begin
            if (full) begin
              if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_OVER;
            end else begin
              sp <= sp + SPW'(1);
            end
          end else if (short) begin
            if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_UNDER;
          end
        end
        pse_pkg::S_EXEC: begin
          if (tok_q.opcode == pse_pkg::OP_DIV && first == '0) begin
            if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_DIV0;
          end
        end
        pse_pkg::S_WRITE: begin
          sp <= sp - SPW'(1);
        end
        pse_pkg::S_FINISH: begin
          if (tok_q.end_of_expr && res_free) begin
            sp  <= '0;
            err <= pse_pkg::ST_OK;
          end
        end
        default: begin
          sp <= sp;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == pse_pkg::S_IDLE && tok_valid) begin
      tok_q <= tok;
    end
    if (mem_we && mem_waddr == '0) begin
      bottom <= mem_wdata;
    end
    if (state == pse_pkg::S_FINISH && tok_q.end_of_expr && res_free) begin
      res.result <= (sp != '0) ? bottom : '0;
      res.status <= err;
    end
    case (state)
      pse_pkg::S_RD_SECOND: begin
        first <= rdata;
      end
      pse_pkg::S_EXEC: begin
        case (tok_q.opcode)
          pse_pkg::OP_MUL: begin
            prod <= 64'(rdata) * 64'(first);
          end
          pse_pkg::OP_DIV: begin
            if (first == '0) begin
              if (rdata > 0) begin
                wres <= pse_pkg::Q_MAX;
              end else if (rdata < 0) begin
                wres <= pse_pkg::Q_MIN;
              end else begin
                wres <= '0;
              end
            end
            div_rem <= '0;
            div_quo <= {second_mag, 16'd0};
            div_dsr <= first_mag;
            div_cnt <= '0;
            div_neg <= rdata[31] ^ first[31];
          end
          default: begin
            wres <= pse_pkg::sat32(48'(addsub));
          end
        endcase
      end
      pse_pkg::S_MUL: begin
        wres <= pse_pkg::sat32(prod[63:16]);
      end
      pse_pkg::S_DIV: begin
        div_rem <= ge ? 32'(trial - {1'b0, div_dsr}) : trial[31:0];
        div_quo <= {div_quo[46:0], ge};
        div_cnt <= div_cnt + CW'(1);
      end
      pse_pkg::S_DIV_FIX: begin
        if (!div_neg) begin
          wres <= (div_quo > 48'h0000_7FFF_FFFF) ? pse_pkg::Q_MAX : div_quo[31:0];
        end else begin
          wres <= (div_quo > 48'h0000_8000_0000) ? pse_pkg::Q_MIN
                                                 : (~div_quo[31:0] + 32'd1);
        end
      end
      default: begin
        first <= first;
      end
    endcase
  end

endmodule

/* test/postfix_stack_evaluator_tb.sv */
// Testbench for the postfix stack evaluator: table-driven and random expressions.
module postfix_stack_evaluator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 64;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 120;
  localparam int DRILL_LEN      = 27;

  typedef struct packed {
    pse_pkg::token_t  tk;
    bit               pin;
    pse_pkg::result_t want;
  } drill_t;

  localparam drill_t DRILL [DRILL_LEN] = '{
    '{'{1'b0, 16'sh7FFF, pse_pkg::OP_ADD, 1'b1}, 1'b1, '{32'sd0, pse_pkg::ST_UNDER}},
    '{'{1'b1, 16'sh7FFF, pse_pkg::OP_MUL, 1'b1}, 1'b1, '{32'sh7FFF_0000, pse_pkg::ST_OK}},
    '{'{1'b1, 16'sh8000, pse_pkg::OP_DIV, 1'b1}, 1'b1, '{pse_pkg::Q_MIN, pse_pkg::ST_OK}},
    '{'{1'b1, 16'sh0005, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh0000, pse_pkg::OP_SUB, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'shFFFF, pse_pkg::OP_DIV, 1'b1}, 1'b1, '{pse_pkg::Q_MAX, pse_pkg::ST_DIV0}},
    '{'{1'b1, 16'shFFFD, pse_pkg::OP_MUL, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh0000, pse_pkg::OP_DIV, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'sh1234, pse_pkg::OP_DIV, 1'b1}, 1'b1, '{pse_pkg::Q_MIN, pse_pkg::ST_DIV0}},
    '{'{1'b1, 16'sh0000, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh0000, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'sh0000, pse_pkg::OP_DIV, 1'b1}, 1'b1, '{32'sd0, pse_pkg::ST_DIV0}},
    '{'{1'b1, 16'sh7FFF, pse_pkg::OP_SUB, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh7FFF, pse_pkg::OP_MUL, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'sh8000, pse_pkg::OP_ADD, 1'b1}, 1'b1, '{pse_pkg::Q_MAX, pse_pkg::ST_OK}},
    '{'{1'b1, 16'sh8000, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh7FFF, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'shFFFF, pse_pkg::OP_SUB, 1'b1}, 1'b1, '{pse_pkg::Q_MIN, pse_pkg::ST_OK}},
    '{'{1'b1, 16'sh7FFF, pse_pkg::OP_DIV, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh8000, pse_pkg::OP_SUB, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'sh0000, pse_pkg::OP_MUL, 1'b1}, 1'b1, '{pse_pkg::Q_MIN, pse_pkg::ST_OK}},
    '{'{1'b1, 16'sh0004, pse_pkg::OP_ADD, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'shAAAA, pse_pkg::OP_SUB, 1'b1}, 1'b1,
      '{32'sh0004_0000, pse_pkg::ST_UNDER}},
    '{'{1'b1, 16'sh0007, pse_pkg::OP_MUL, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'shFFFD, pse_pkg::OP_SUB, 1'b0}, 1'b0, '0},
    '{'{1'b0, 16'sh5555, pse_pkg::OP_DIV, 1'b0}, 1'b0, '0},
    '{'{1'b1, 16'sh0009, pse_pkg::OP_ADD, 1'b1}, 1'b0, '0}
  };

  logic             clk;
  logic             rst       = 1'b1;
  logic             tok_valid = 1'b0;
  logic             tok_stall;
  pse_pkg::token_t  tok       = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  pse_pkg::result_t res;

  bit               tok_pinned     = 1'b0;
  pse_pkg::result_t tok_pinned_res = '0;
  bit               hold_request   = 1'b0;
  int               tokens_sent    = 0;
  int               burst_left     = 0;
  int               mismatch_count = 0;
  int               idle_cycles    = 0;

  logic signed [31:0] eval_stack [DEPTH];
  int                 eval_depth  = 0;
  logic [1:0]         eval_status = pse_pkg::ST_OK;
  pse_pkg::result_t   awaited_results [$];

  postfix_stack_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok      (tok),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] saturate(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = pse_pkg::Q_MAX;
    end else if (x < -64'sd2147483648) begin
      r = pse_pkg::Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic void note_error(input logic [1:0] code);
    if (eval_status == pse_pkg::ST_OK) begin
      eval_status = code;
    end
  endfunction

  function automatic bit evaluate_token(input pse_pkg::token_t t,
                                        output pse_pkg::result_t r);
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    logic signed [63:0] prod;
    logic signed [31:0] val;
    r   = '0;
    val = '0;
    if (t.is_operand) begin
      if (eval_depth >= DEPTH) begin
        note_error(pse_pkg::ST_OVER);
      end else begin
        eval_stack[eval_depth] = {t.operand_value, 16'h0000};
        eval_depth++;
      end
    end else if (eval_depth < 2) begin
      note_error(pse_pkg::ST_UNDER);
    end else begin
      lhs = eval_stack[eval_depth - 2];
      rhs = eval_stack[eval_depth - 1];
      case (t.opcode)
        pse_pkg::OP_ADD: val = saturate(lhs + rhs);
        pse_pkg::OP_SUB: val = saturate(lhs - rhs);
        pse_pkg::OP_MUL: begin
          prod = lhs * rhs;
          val  = saturate(prod >>> 16);
        end
        pse_pkg::OP_DIV: begin
          if (rhs == 0) begin
            note_error(pse_pkg::ST_DIV0);
            if (lhs > 0) begin
              val = pse_pkg::Q_MAX;
            end else if (lhs < 0) begin
              val = pse_pkg::Q_MIN;
            end
          end else begin
            val = saturate((lhs <<< 16) / rhs);
          end
        end
        default: val = '0;
      endcase
      eval_stack[eval_depth - 2] = val;
      eval_depth--;
    end
    if (!t.end_of_expr) begin
      return 1'b0;
    end
    r.result    = (eval_depth > 0) ? eval_stack[0] : 32'sd0;
    r.status    = eval_status;
    eval_depth  = 0;
    eval_status = pse_pkg::ST_OK;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    pse_pkg::result_t want;
    pse_pkg::result_t predicted;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: result %0d, status %0d",
                 res.result, res.status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (res.result !== want.result) begin
            $error("result: expected %0d, actual %0d", want.result, res.result);
            mismatch_count++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res.status);
            mismatch_count++;
          end
        end
      end
      if (tok_valid && !tok_stall) begin
        if (evaluate_token(tok, predicted)) begin
          awaited_results.push_back(tok_pinned ? tok_pinned_res : predicted);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (tok_valid && !tok_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls in stretches of its own, and holds off for a long spell on request.
  initial begin : receiver
    int span;
    int mode;
    int hold_count;
    hold_count = 0;
    forever begin
      span = $urandom_range(4, 40);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk);
        if (hold_count > 0) begin
          hold_count--;
          res_stall <= 1'b1;
        end else if (hold_request) begin
          hold_request = 1'b0;
          hold_count   = HOLD_CYCLES;
          res_stall <= 1'b1;
        end else begin
          case (mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= 1'($urandom_range(0, 1));
            default: res_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_token(input pse_pkg::token_t t, input bit pin,
                            input pse_pkg::result_t pinned);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
    end else begin
      gap = 0;
    end
    @(negedge clk);
    if (gap > 0) begin
      tok_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tok_valid      <= 1'b1;
    tok            <= t;
    tok_pinned     <= pin;
    tok_pinned_res <= pinned;
    burst_left--;
    tokens_sent++;
    do @(posedge clk); while (tok_stall);
  endtask

  task automatic release_sender();
    @(negedge clk);
    tok_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = int'($urandom_range(0, 16)) - 8;
        return v[15:0];
      end
      4:       return 16'h0000;
      5:       return 16'h7FFF;
      6:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pse_pkg::token_t operand_token();
    pse_pkg::token_t t;
    t.is_operand    = 1'b1;
    t.operand_value = pick_value();
    t.opcode        = 2'($urandom);
    t.end_of_expr   = 1'b0;
    return t;
  endfunction

  function automatic pse_pkg::token_t operator_token();
    pse_pkg::token_t t;
    t.is_operand    = 1'b0;
    t.operand_value = 16'($urandom);
    t.opcode        = 2'($urandom_range(0, 3));
    t.end_of_expr   = 1'b0;
    return t;
  endfunction

  task automatic send_expression();
    pse_pkg::token_t expr [$];
    int              pick;
    int              n;
    int              pushed;
    int              depth;
    bit              leave;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      n = DEPTH + $urandom_range(1, 4);
      repeat (n) expr.push_back(operand_token());
      repeat ($urandom_range(0, 3)) expr.push_back(operator_token());
    end else if (pick < 85) begin
      n      = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      leave  = ($urandom_range(0, 7) == 0);
      pushed = 0;
      depth  = 0;
      while (pushed < n || (depth > 1 && !leave)) begin
        if (pushed < n && (depth < 2 || $urandom_range(0, 1) == 1)) begin
          expr.push_back(operand_token());
          pushed++;
          depth++;
        end else begin
          expr.push_back(operator_token());
          depth--;
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        expr.push_back($urandom_range(0, 1) ? operand_token() : operator_token());
      end
    end
    expr[expr.size() - 1].end_of_expr = 1'b1;
    foreach (expr[i]) send_token(expr[i], 1'b0, '0);
  endtask

  initial begin : stimulus
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DRILL_LEN; i++) begin
      send_token(DRILL[i].tk, DRILL[i].pin, DRILL[i].want);
    end
    release_sender();
    while (awaited_results.size() != 0) @(posedge clk);

    while (tokens_sent < DRILL_LEN + RANDOM_ITEMS) begin
      if (!held && tokens_sent >= DRILL_LEN + 400) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      if (!drained && tokens_sent >= DRILL_LEN + 900) begin
        drained = 1'b1;
        release_sender();
        while (awaited_results.size() != 0) @(posedge clk);
      end
      send_expression();
    end
    release_sender();

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
